/* hdl/baro_sensor_compensation_unit_macros.svh */
// Assertion helpers for the compensation pipeline.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/bsc_pkg.sv */
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_SLOPE      = 3'd5;

    // 20.00 C, and the -15.00 C knee given as its distance below 20.00 C
    localparam logic signed [TEMP_W-1:0] TEMP_REF      = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW_REL = 19'sd3500;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in_beat;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_centi;
    } t_out_beat;

endpackage

/* hdl/baro_sensor_compensation_unit.sv */
`timescale 1ns / 1ps
// Second-order barometric compensation. Each input beat carries one raw
// pressure and one raw temperature conversion; each output beat carries the
// temperature in 0.01 C and the pressure in 0.01 mbar. The block is a
// nine-stage pipeline: a beat can enter every cycle unless the output side
// stalls while every stage is full, and a result is held on the output until
// it is taken. A stall only halts the stages that are full, so empty slots
// still fill while a result waits. The longest product, raw pressure times
// the 40-bit sensitivity, is split into two 20-bit halves over two stages.
// Calibration words are written through the register port; the user writes
// them while no beat is in flight, which the block itself does not enforce.
`include "baro_sensor_compensation_unit_macros.svh"
module baro_sensor_compensation_unit
    import bsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAL_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data
);

    localparam int NSTG = 9;

    // calibration words
    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    // stage 0: dT
    logic [RAW_W-1:0]   r0_d1;
    logic signed [24:0] r0_dt;
    // stage 1: products with dT
    logic [RAW_W-1:0]   r1_d1;
    logic signed [41:0] r1_pt, r1_poff, r1_psens;
    logic signed [49:0] r1_pdt2;
    // stage 2: first-order terms
    logic [RAW_W-1:0]        r2_d1;
    logic signed [TEMP_W-1:0] r2_temp, r2_lo, r2_vl;
    logic signed [36:0]      r2_off;
    logic signed [35:0]      r2_sens;
    logic [16:0]             r2_t2;
    logic                    r2_low, r2_vlow;
    // stage 3: squares
    logic [RAW_W-1:0]        r3_d1;
    logic signed [TEMP_W-1:0] r3_temp;
    logic [34:0]             r3_lo2, r3_vl2;
    logic signed [36:0]      r3_off;
    logic signed [35:0]      r3_sens;
    logic [16:0]             r3_t2;
    logic                    r3_low, r3_vlow;
    // stage 4: second-order corrections
    logic [RAW_W-1:0]        r4_d1;
    logic signed [TEMP_W-1:0] r4_temp;
    logic [39:0]             r4_off2;
    logic [38:0]             r4_sens2;
    logic signed [36:0]      r4_off;
    logic signed [35:0]      r4_sens;
    logic [16:0]             r4_t2;
    logic                    r4_low;
    // stage 5: corrected terms
    logic [RAW_W-1:0]        r5_d1;
    logic signed [TEMP_W-1:0] r5_temp;
    logic signed [41:0]      r5_off;
    logic signed [39:0]      r5_sens;
    // stage 6: partial products
    logic [43:0]             r6_pp_lo;
    logic signed [44:0]      r6_pp_hi;
    logic signed [TEMP_W-1:0] r6_temp;
    logic signed [41:0]      r6_off;
    // stage 7: full product
    logic signed [63:0]      r7_prod;
    logic signed [TEMP_W-1:0] r7_temp;
    logic signed [41:0]      r7_off;
    // stage 8: output
    t_out_beat               r8_out;

    // combinational per stage
    logic signed [24:0]      w0_dt;
    logic signed [16:0]      w1_c6, w1_c4, w1_c3;
    logic signed [41:0]      w1_pt, w1_poff, w1_psens;
    logic signed [49:0]      w1_pdt2;
    logic signed [TEMP_W-1:0] w2_lo;
    logic signed [36:0]      w2_off;
    logic signed [35:0]      w2_sens;
    logic signed [37:0]      w3_lo2, w3_vl2;
    logic [40:0]             w4_lo61;
    logic [39:0]             w4_off2;
    logic [38:0]             w4_sens2;
    logic signed [TEMP_W-1:0] w5_temp;
    logic signed [41:0]      w5_off;
    logic signed [39:0]      w5_sens;
    logic [43:0]             w6_pp_lo;
    logic signed [44:0]      w6_pp_hi;
    logic signed [63:0]      w7_prod;
    logic signed [43:0]      w8_diff;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESSURE_SENSITIVITY:   r_c1 <= i_cfg_data;
                CFG_PRESSURE_OFFSET:        r_c2 <= i_cfg_data;
                CFG_SENSITIVITY_TEMP_COEFF: r_c3 <= i_cfg_data;
                CFG_OFFSET_TEMP_COEFF:      r_c4 <= i_cfg_data;
                CFG_REFERENCE_TEMPERATURE:  r_c5 <= i_cfg_data;
                CFG_TEMPERATURE_SLOPE:      r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or the stage after it can move
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_adv[k] = i_out_ready ||
                ((r_vld | ((NSTG'(1) << k) - NSTG'(1))) != {NSTG{1'b1}});
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r8_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // datapath
    assign w0_dt = $signed({1'b0, i_in_data.raw_temperature})
                 - $signed({1'b0, r_c5, 8'd0});

    assign w1_c6    = $signed({1'b0, r_c6});
    assign w1_c4    = $signed({1'b0, r_c4});
    assign w1_c3    = $signed({1'b0, r_c3});
    assign w1_pt    = 42'(r0_dt) * 42'(w1_c6);
    assign w1_poff  = 42'(r0_dt) * 42'(w1_c4);
    assign w1_psens = 42'(r0_dt) * 42'(w1_c3);
    assign w1_pdt2  = 50'(r0_dt) * 50'(r0_dt);

    assign w2_lo   = r1_pt[41:23];
    assign w2_off  = $signed({4'd0, r_c2, 17'd0}) + $signed({r1_poff[41], r1_poff[41:6]});
    assign w2_sens = $signed({4'd0, r_c1, 16'd0}) + $signed({r1_psens[41], r1_psens[41:7]});

    assign w3_lo2 = 38'(r2_lo) * 38'(r2_lo);
    assign w3_vl2 = 38'(r2_vl) * 38'(r2_vl);

    assign w4_lo61  = 41'(r3_lo2) * 41'd61;
    assign w4_off2  = 40'(w4_lo61[40:4]) + (r3_vlow ? 40'(r3_vl2) * 40'd15 : 40'd0);
    assign w4_sens2 = 39'({r3_lo2, 1'b0}) + (r3_vlow ? 39'({r3_vl2, 3'd0}) : 39'd0);

    always_comb begin
        w5_temp = r4_temp;
        w5_off  = 42'(r4_off);
        w5_sens = 40'(r4_sens);
        if (r4_low) begin
            w5_temp = r4_temp - $signed({2'd0, r4_t2});
            w5_off  = 42'(r4_off) - $signed({2'd0, r4_off2});
            w5_sens = 40'(r4_sens) - $signed({1'b0, r4_sens2});
        end
    end

    assign w6_pp_lo = 44'(r5_d1) * 44'(r5_sens[19:0]);
    assign w6_pp_hi = 45'($signed({1'b0, r5_d1})) * 45'($signed(r5_sens[39:20]));

    assign w7_prod = (64'(r6_pp_hi) <<< 20) + $signed({20'd0, r6_pp_lo});

    // the shifted difference keeps 29 bits, sign-extended to the 32-bit output
    assign w8_diff = 44'($signed(r7_prod[63:21])) - 44'(r7_off);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_d1 <= i_in_data.raw_pressure;
            r0_dt <= w0_dt;
        end
        if (w_adv[1]) begin
            r1_d1    <= r0_d1;
            r1_pt    <= w1_pt;
            r1_poff  <= w1_poff;
            r1_psens <= w1_psens;
            r1_pdt2  <= w1_pdt2;
        end
        if (w_adv[2]) begin
            r2_d1   <= r1_d1;
            r2_lo   <= w2_lo;
            r2_temp <= w2_lo + TEMP_REF;
            r2_vl   <= w2_lo + TEMP_VLOW_REL;
            r2_off  <= w2_off;
            r2_sens <= w2_sens;
            r2_t2   <= r1_pdt2[47:31];
            r2_low  <= w2_lo[TEMP_W-1];
            r2_vlow <= w2_lo < -TEMP_VLOW_REL;
        end
        if (w_adv[3]) begin
            r3_d1   <= r2_d1;
            r3_temp <= r2_temp;
            r3_lo2  <= w3_lo2[34:0];
            r3_vl2  <= w3_vl2[34:0];
            r3_off  <= r2_off;
            r3_sens <= r2_sens;
            r3_t2   <= r2_t2;
            r3_low  <= r2_low;
            r3_vlow <= r2_vlow;
        end
        if (w_adv[4]) begin
            r4_d1    <= r3_d1;
            r4_temp  <= r3_temp;
            r4_off2  <= w4_off2;
            r4_sens2 <= w4_sens2;
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_t2    <= r3_t2;
            r4_low   <= r3_low;
        end
        if (w_adv[5]) begin
            r5_d1   <= r4_d1;
            r5_temp <= w5_temp;
            r5_off  <= w5_off;
            r5_sens <= w5_sens;
        end
        if (w_adv[6]) begin
            r6_pp_lo <= w6_pp_lo;
            r6_pp_hi <= w6_pp_hi;
            r6_temp  <= r5_temp;
            r6_off   <= r5_off;
        end
        if (w_adv[7]) begin
            r7_prod <= w7_prod;
            r7_temp <= r6_temp;
            r7_off  <= r6_off;
        end
        if (w_adv[8]) begin
            r8_out.temperature_centi <= r7_temp;
            r8_out.pressure_centi    <= {{3{w8_diff[43]}}, w8_diff[43:15]};
        end
    end

    `BSC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])
    `BSC_ASSERT_NOW(a_drain_frees_input, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready)
    `BSC_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, r_vld == '0, o_in_ready)
    `BSC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_vld[4] && !w_adv[5], r_vld[4])

endmodule
